FILE: design/mfd_pkg.sv
// Shared types and constants for the marker-framed packet deframer.
package mfd_pkg;

    localparam int BYTE_W    = 8;
    localparam int PLEN_W    = 6;
    localparam int BIDX_W    = 5;
    localparam int CFG_IDX_W = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = CFG_IDX_W'(1);

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h55;

    // Result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_SUM = 1'b1;

    typedef struct packed {
        logic              frame_status;
        logic [BYTE_W-1:0] command_id;
        logic [PLEN_W-1:0] payload_length;
        logic [BYTE_W-1:0] payload_byte;
        logic [BIDX_W-1:0] byte_index;
        logic              last_of_frame;
    } res_t;

endpackage

FILE: design/mfd_if.sv
// Channel interfaces: received bytes, frame results and configuration writes.
interface mfd_rx_if import mfd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mfd_res_if import mfd_pkg::*;;
    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mfd_cfg_if import mfd_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/mfd_store.sv
// Payload store: one write port, one read port with registered read data.
module mfd_store
    import mfd_pkg::*;
#(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [BYTE_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/mfd_ctrl.sv
// Frame parser and result drain sequencer around the payload store.
module mfd_ctrl
    import mfd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32,
    parameter int LEN_W       = 6,
    parameter int ADDR_W      = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [BYTE_W-1:0] start_marker,
    input  logic [BYTE_W-1:0] end_marker,
    mfd_rx_if.sink            rx,
    mfd_res_if.source         res,
    output logic              we,
    output logic [ADDR_W-1:0] waddr,
    output logic [BYTE_W-1:0] wdata,
    output logic [ADDR_W-1:0] raddr,
    input  logic [BYTE_W-1:0] rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD,
        S_LEN,
        S_DATA,
        S_CHECK,
        S_END,
        S_DRAIN
    } state_t;

    state_t            state_reg, state_next;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [BYTE_W-1:0] check_reg, check_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic              err_reg, err_next;
    logic              empty_reg, empty_next;

    logic              rx_acc;
    logic              res_acc;
    logic [LEN_W-1:0]  fill_inc;
    logic              drain_last;
    logic              single;

    assign rx_acc   = rx.valid && rx.ready;
    assign res_acc  = res.valid && res.ready;
    assign fill_inc = fill_reg + LEN_W'(1);
    assign single   = err_reg || empty_reg;
    assign drain_last = ({1'b0, fill_reg} + {{LEN_W{1'b0}}, 1'b1}) == {1'b0, len_reg};

    assign rx.ready  = (state_reg != S_DRAIN);
    assign res.valid = (state_reg == S_DRAIN);

    assign res.data.frame_status   = err_reg ? STATUS_BAD_SUM : STATUS_OK;
    assign res.data.command_id     = cmd_reg;
    assign res.data.payload_length = PLEN_W'(len_reg);
    assign res.data.payload_byte   = single ? '0 : rdata;
    assign res.data.byte_index     = single ? '0 : BIDX_W'(fill_reg);
    assign res.data.last_of_frame  = single || drain_last;

    assign we    = (state_reg == S_DATA) && rx_acc;
    assign waddr = fill_reg[ADDR_W-1:0];
    assign wdata = rx.rx_byte;

    // Read ahead so the next payload byte is ready the cycle after a transaction
    always_comb
    begin
        if (state_reg == S_DRAIN)
        begin
            raddr = res_acc ? fill_inc[ADDR_W-1:0] : fill_reg[ADDR_W-1:0];
        end
        else
        begin
            raddr = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        fill_next  = fill_reg;
        check_next = check_reg;
        sum_next   = sum_reg;
        err_next   = err_reg;
        empty_next = empty_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (rx_acc && rx.rx_byte == start_marker)
                begin
                    state_next = S_CMD;
                end
            end
            S_CMD:
            begin
                if (rx_acc)
                begin
                    cmd_next   = rx.rx_byte;
                    sum_next   = rx.rx_byte;
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                if (rx_acc)
                begin
                    if (rx.rx_byte == '0)
                    begin
                        len_next   = '0;
                        state_next = S_CHECK;
                    end
                    else if (rx.rx_byte > BYTE_W'(MAX_PAYLOAD))
                    begin
                        // drop oversized frame
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        len_next   = LEN_W'(rx.rx_byte);
                        fill_next  = '0;
                        state_next = S_DATA;
                    end
                end
            end
            S_DATA:
            begin
                if (rx_acc)
                begin
                    sum_next  = sum_reg + rx.rx_byte;
                    fill_next = fill_inc;
                    if (fill_inc >= len_reg)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (rx_acc)
                begin
                    check_next = rx.rx_byte;
                    state_next = S_END;
                end
            end
            S_END:
            begin
                if (rx_acc)
                begin
                    if (rx.rx_byte == end_marker)
                    begin
                        err_next   = (sum_reg != check_reg);
                        empty_next = (len_reg == '0);
                        fill_next  = '0;
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DRAIN:
            begin
                if (res_acc)
                begin
                    if (single || drain_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        fill_next = fill_inc;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg   <= '0;
            len_reg   <= '0;
            fill_reg  <= '0;
            check_reg <= '0;
            sum_reg   <= '0;
            err_reg   <= 1'b0;
            empty_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            fill_reg  <= fill_next;
            check_reg <= check_next;
            sum_reg   <= sum_next;
            err_reg   <= err_next;
            empty_reg <= empty_next;
        end
    end

endmodule

FILE: design/marker_framed_packet_deframer.sv
// Marker-framed packet deframer: parses start/cmd/len/payload/checksum/end frames.
//
// Channels: rx carries one received byte per transaction; res carries one
// result per transaction; cfg writes start_marker (index 0) or end_marker
// (index 1), other indexes are ignored. cfg is always ready.
// Payload bytes are stored in a single-port-write, registered-read memory of
// MAX_PAYLOAD bytes. A good frame with N payload bytes gives N results, one
// per cycle while res is ready, the first in the cycle after the end marker
// is accepted. An empty frame or a checksum mismatch gives one result. The
// drain rate is set by the memory read port, read one entry ahead of the
// output: one byte per cycle while res is ready. rx.ready is low while
// results drain, so the parser takes no new bytes until the last result of
// a frame is accepted.
// Oversized lengths and wrong end bytes drop the frame with no result.
// A stall on res holds the current result and the parser; nothing is lost.
// Reset returns the parser to waiting for a start marker and loads the
// markers with 0xAA and 0x55; the payload memory is not cleared.
module marker_framed_packet_deframer
    import mfd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    mfd_rx_if.sink    rx,
    mfd_res_if.source res,
    mfd_cfg_if.sink   cfg
);

    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [BYTE_W-1:0] start_marker_reg;
    logic [BYTE_W-1:0] end_marker_reg;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
    logic [BYTE_W-1:0] rdata;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RST;
            end_marker_reg   <= END_MARKER_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_START_MARKER: start_marker_reg <= cfg.data;
                REG_END_MARKER:   end_marker_reg   <= cfg.data;
                default:          ;
            endcase
        end
    end

    mfd_ctrl #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .LEN_W       (LEN_W),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_marker (start_marker_reg),
        .end_marker   (end_marker_reg),
        .rx           (rx),
        .res          (res),
        .we           (we),
        .waddr        (waddr),
        .wdata        (wdata),
        .raddr        (raddr),
        .rdata        (rdata)
    );

    mfd_store #(
        .DEPTH  (MAX_PAYLOAD),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the marker-framed packet deframer.
`timescale 1ns / 100ps

module tb_top;
    import mfd_pkg::*;

    localparam int MAX_PAYLOAD  = 32;
    localparam int PIDX_W       = $clog2(MAX_PAYLOAD);
    localparam int IDLE_SETTLE  = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 20;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_END_MARKER + CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

    typedef enum logic [2:0] {
        WAIT_START,
        GET_CMD,
        GET_LEN,
        GET_DATA,
        GET_CHECK,
        GET_END
    } parse_phase_t;

    logic clk;
    logic rst_n;

    mfd_rx_if  rx_ch();
    mfd_res_if res_ch();
    mfd_cfg_if cfg_ch();

    marker_framed_packet_deframer i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // Frame parser shadow state
    logic [BYTE_W-1:0] start_mark;
    logic [BYTE_W-1:0] end_mark;
    parse_phase_t      phase;
    logic [BYTE_W-1:0] cmd_hold;
    logic [PLEN_W-1:0] len_hold;
    int                fill;
    logic [BYTE_W-1:0] check_hold;
    logic [BYTE_W-1:0] sum_acc;
    logic [BYTE_W-1:0] payload_copy [MAX_PAYLOAD];

    res_t              frame_results_due [$];
    logic [BYTE_W-1:0] frame_payload [MAX_PAYLOAD];

    int send_gap_max  = 11;
    int res_stall_max = 11;
    int bytes_sent    = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int marker_sets   = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Feed one received byte through the shadow parser and queue what it emits.
    function automatic void parse_rx_byte(input logic [BYTE_W-1:0] b);
        res_t r;
        int   i;
        case (phase)
            WAIT_START:
                if (b == start_mark)
                    phase = GET_CMD;
            GET_CMD:
            begin
                cmd_hold = b;
                sum_acc  = b;
                phase    = GET_LEN;
            end
            GET_LEN:
            begin
                if (b == 0)
                begin
                    len_hold = '0;
                    phase    = GET_CHECK;
                end
                else if (b > MAX_PAYLOAD)
                    phase = WAIT_START;
                else
                begin
                    len_hold = b[PLEN_W-1:0];
                    fill     = 0;
                    phase    = GET_DATA;
                end
            end
            GET_DATA:
            begin
                payload_copy[PIDX_W'(fill)] = b;
                sum_acc = sum_acc + b;
                fill++;
                if (fill >= len_hold)
                    phase = GET_CHECK;
            end
            GET_CHECK:
            begin
                check_hold = b;
                phase      = GET_END;
            end
            GET_END:
            begin
                if (b == end_mark)
                begin
                    r.command_id     = cmd_hold;
                    r.payload_length = len_hold;
                    r.payload_byte   = '0;
                    r.byte_index     = '0;
                    r.last_of_frame  = 1'b1;
                    if (sum_acc != check_hold)
                    begin
                        r.frame_status = STATUS_BAD_SUM;
                        frame_results_due.push_back(r);
                    end
                    else if (len_hold == 0)
                    begin
                        r.frame_status = STATUS_OK;
                        frame_results_due.push_back(r);
                    end
                    else
                    begin
                        r.frame_status = STATUS_OK;
                        for (i = 0; i < len_hold; i++)
                        begin
                            r.payload_byte  = payload_copy[PIDX_W'(i)];
                            r.byte_index    = i[BIDX_W-1:0];
                            r.last_of_frame = (i + 1 == len_hold);
                            frame_results_due.push_back(r);
                        end
                    end
                end
                phase = WAIT_START;
            end
            default:
                phase = WAIT_START;
        endcase
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        res_t want;
        res_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = res_ch.data;
            results_seen++;
            if (frame_results_due.size() == 0)
            begin
                $error("result with nothing pending: cmd 0x%0h byte 0x%0h",
                       got.command_id, got.payload_byte);
                mismatches++;
            end
            else
            begin
                want = frame_results_due.pop_front();
                check_field("frame_status", 32'(want.frame_status), 32'(got.frame_status));
                check_field("command_id", 32'(want.command_id), 32'(got.command_id));
                check_field("payload_length", 32'(want.payload_length),
                            32'(got.payload_length));
                check_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
                check_field("byte_index", 32'(want.byte_index), 32'(got.byte_index));
                check_field("last_of_frame", 32'(want.last_of_frame),
                            32'(got.last_of_frame));
            end
        end
    end

    // Result receiver: random stall before taking each transaction.
    initial
    begin : result_sink
        int stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = $urandom_range(0, res_stall_max);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top: errors");
        $finish;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        parse_rx_byte(b);
        bytes_sent++;
    endtask

    // Payload comes from frame_payload; sum_flip corrupts the checksum when nonzero.
    task automatic send_frame(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] len,
                              input logic [BYTE_W-1:0] sum_flip,
                              input logic [BYTE_W-1:0] end_byte);
        logic [BYTE_W-1:0] sum;
        sum = cmd;
        send_byte(start_mark);
        send_byte(cmd);
        send_byte(len);
        if (len <= MAX_PAYLOAD)
        begin
            for (int i = 0; i < len; i++)
            begin
                sum = sum + frame_payload[PIDX_W'(i)];
                send_byte(frame_payload[PIDX_W'(i)]);
            end
            send_byte(sum ^ sum_flip);
            send_byte(end_byte);
        end
    endtask

    // Bring the parser back to idle, drop valid and let all results drain.
    task automatic idle_link();
        while (phase != WAIT_START)
            send_byte(~end_mark);
        rx_ch.valid <= 1'b0;
        while (frame_results_due.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic write_marker_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [BYTE_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        if (idx == REG_START_MARKER)
            start_mark = value;
        else if (idx == REG_END_MARKER)
            end_mark = value;
    endtask

    task automatic random_frame(output int frame_bytes);
        int                pick;
        int                sent_at_start;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] flip;
        logic [BYTE_W-1:0] end_byte;
        logic [BYTE_W-1:0] noise;
        pick = $urandom_range(0, 9);
        case (pick)
            0: len = '0;
            1: len = BYTE_W'(MAX_PAYLOAD);
            2: len = BYTE_W'($urandom_range(MAX_PAYLOAD + 1, 255));
            3: len = BYTE_W'($urandom_range(9, MAX_PAYLOAD - 1));
            default: len = BYTE_W'($urandom_range(1, 8));
        endcase
        // mix marker values into the payload now and then
        for (int i = 0; i < MAX_PAYLOAD; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                frame_payload[PIDX_W'(i)] = $urandom_range(0, 1) ? start_mark : end_mark;
            else
                frame_payload[PIDX_W'(i)] = BYTE_W'($urandom_range(0, 255));
        end
        flip = ($urandom_range(0, 7) == 0) ? BYTE_W'($urandom_range(1, 255)) : '0;
        end_byte = end_mark;
        if ($urandom_range(0, 9) == 0)
            end_byte = end_mark ^ BYTE_W'($urandom_range(1, 255));
        if ($urandom_range(0, 5) == 0)
        begin
            do
                noise = BYTE_W'($urandom_range(0, 255));
            while (noise == start_mark);
            send_byte(noise);
        end
        sent_at_start = bytes_sent;
        send_frame(BYTE_W'($urandom_range(0, 255)), len, flip, end_byte);
        frame_bytes = bytes_sent - sent_at_start;
    endtask

    task automatic test_random_frames(input int n_bytes);
        int done;
        int got;
        done = 0;
        while (done < n_bytes)
        begin
            random_frame(got);
            done += got;
        end
    endtask

    task automatic test_directed_frames();
        // idle bytes other than the start marker are dropped
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(8'hFF, 8'd0, 8'h00, end_mark);
        // markers inside the payload are plain data
        frame_payload[0] = 8'h00;
        frame_payload[1] = 8'hFF;
        frame_payload[2] = start_mark;
        frame_payload[3] = end_mark;
        send_frame(8'h00, 8'd4, 8'h00, end_mark);
        send_frame(8'h5A, 8'd0, 8'h01, end_mark);
        send_frame(8'h11, BYTE_W'(MAX_PAYLOAD + 1), 8'h00, end_mark);
        send_frame(8'h22, 8'd0, 8'h00, ~end_mark);
    endtask

    task automatic test_marker_setting(input logic [BYTE_W-1:0] new_start,
                                       input logic [BYTE_W-1:0] new_end,
                                       input int n_bytes, input int gap_max);
        idle_link();
        write_marker_reg(REG_START_MARKER, new_start);
        write_marker_reg(REG_END_MARKER, new_end);
        marker_sets++;
        send_gap_max  = gap_max;
        res_stall_max = gap_max;
        test_random_frames(n_bytes);
    endtask

    task automatic test_max_payload();
        for (int i = 0; i < MAX_PAYLOAD; i++)
            frame_payload[PIDX_W'(i)] = BYTE_W'($urandom_range(0, 255));
        send_frame(BYTE_W'($urandom_range(0, 255)), BYTE_W'(MAX_PAYLOAD), 8'h00, end_mark);
    endtask

    task automatic test_unused_register_index();
        idle_link();
        write_marker_reg(REG_UNUSED_LO, BYTE_W'($urandom_range(0, 255)));
        write_marker_reg(REG_UNUSED_HI, BYTE_W'($urandom_range(0, 255)));
        frame_payload[0] = BYTE_W'($urandom_range(0, 255));
        send_frame(BYTE_W'($urandom_range(0, 255)), 8'd1, 8'h00, end_mark);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        res_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        start_mark     = START_MARKER_RST;
        end_mark       = END_MARKER_RST;
        phase          = WAIT_START;
        cmd_hold       = '0;
        len_hold       = '0;
        fill           = 0;
        check_hold     = '0;
        sum_acc        = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_random_frames(25);
        test_marker_setting(8'h00, 8'hFF, 20, 11);
        test_max_payload();
        test_unused_register_index();
        test_marker_setting(8'hFF, 8'h00, 20, 0);
        test_marker_setting(BYTE_W'($urandom_range(0, 255)),
                            BYTE_W'($urandom_range(0, 255)), 20, 11);

        idle_link();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (frame_results_due.size() != 0)
        begin
            $error("%0d results never arrived", frame_results_due.size());
            mismatches++;
        end
        $display("tb_top: %0d bytes sent, %0d results checked, %0d marker settings beyond reset",
                 bytes_sent, results_seen, marker_sets);
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
